/* rtl/wal_pkg.sv */
`default_nettype none

package wal_pkg;

   // table geometry
   localparam int LOG_ENTRIES = 30;
   localparam int IDX_W       = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(LOG_ENTRIES + 1);

   // field widths, fixed apart from NEED_W
   localparam int BLK_W      = 24;
   localparam int LBLK_W     = 8;
   localparam int BPO_W      = 5;
   localparam int HCNT_W     = 5;
   localparam int STAT_W     = 3;
   localparam int KIND_W     = 2;
   localparam int TYPE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int NEED_W     = CNT_W + BPO_W + 2;
   localparam int UPC_W      = 5;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

   // result item types
   localparam logic [TYPE_W-1:0] ITEM_STATUS = 2'd0;
   localparam logic [TYPE_W-1:0] ITEM_COPY   = 2'd1;
   localparam logic [TYPE_W-1:0] ITEM_HEADER = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_WAIT      = 3'd1;
   localparam logic [STAT_W-1:0] ST_TOO_BIG   = 3'd2;
   localparam logic [STAT_W-1:0] ST_NO_OP_WR  = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_OP_END = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_BLOCKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BPO        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP       = 2'd3;

   // register reset values
   localparam logic [BLK_W-1:0]  RST_LOG_START  = 24'd2;
   localparam logic [LBLK_W-1:0] RST_LOG_BLOCKS = 8'd30;
   localparam logic [BPO_W-1:0]  RST_BPO        = 5'd10;

   // microcode jump conditions
   localparam logic [3:0] C_NEVER        = 4'd0;
   localparam logic [3:0] C_ALWAYS       = 4'd1;
   localparam logic [3:0] C_NO_REQ       = 4'd2;
   localparam logic [3:0] C_KIND_BEGIN   = 4'd3;
   localparam logic [3:0] C_KIND_WRITE   = 4'd4;
   localparam logic [3:0] C_KIND_NOT_END = 4'd5;
   localparam logic [3:0] C_NO_OPEN      = 4'd6;
   localparam logic [3:0] C_NO_COMMIT    = 4'd7;
   localparam logic [3:0] C_BEGIN_WAIT   = 4'd8;
   localparam logic [3:0] C_FULL         = 4'd9;
   localparam logic [3:0] C_IDX_DONE     = 4'd10;
   localparam logic [3:0] C_IDX_NOT_LAST = 4'd11;
   localparam logic [3:0] C_NOT_MATCH    = 4'd12;
   localparam logic [3:0] C_STOP         = 4'd13;

   // emit operations
   localparam logic [2:0] E_NONE       = 3'd0;
   localparam logic [2:0] E_STATUS     = 3'd1;
   localparam logic [2:0] E_COPY_IN    = 3'd2;
   localparam logic [2:0] E_HDR_COMMIT = 3'd3;
   localparam logic [2:0] E_COPY_OUT   = 3'd4;
   localparam logic [2:0] E_HDR_CLEAR  = 3'd5;

   // last-flag select
   localparam logic [1:0] L_NO   = 2'd0;
   localparam logic [1:0] L_YES  = 2'd1;
   localparam logic [1:0] L_STOP = 2'd2;

   // index counter ops
   localparam logic [1:0] IX_HOLD = 2'd0;
   localparam logic [1:0] IX_CLR  = 2'd1;
   localparam logic [1:0] IX_INC  = 2'd2;

   // open-operation counter ops
   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_INC  = 2'd1;
   localparam logic [1:0] OP_DEC  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BLK_W-1:0]  block_number;
   } req_type;

   typedef struct packed {
      logic [TYPE_W-1:0] item_type;
      logic [STAT_W-1:0] status;
      logic              pin_request;
      logic [BLK_W-1:0]  source_block;
      logic [BLK_W-1:0]  target_block;
      logic [HCNT_W-1:0] header_count;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        cond;
      logic [UPC_W-1:0]  target;
      logic [2:0]        emit;
      logic [STAT_W-1:0] status;
      logic              pin;
      logic [1:0]        last_sel;
      logic [1:0]        idx_op;
      logic [1:0]        open_op;
      logic              append;
      logic              count_clr;
      logic              take_req;
   } uword_type;

   typedef struct packed {
      logic no_req;
      logic kind_begin;
      logic kind_write;
      logic kind_not_end;
      logic no_open;
      logic no_commit;
      logic begin_wait;
      logic full;
      logic idx_done;
      logic idx_not_last;
      logic not_match;
      logic stop;
      logic out_free;
   } flags_type;

endpackage

`default_nettype wire

/* rtl/wal_seq.sv */
`default_nettype none

module wal_seq (
   input  logic               clock,
   input  logic               reset,
   input  wal_pkg::flags_type flags,
   output wal_pkg::uword_type ctl
);
   import wal_pkg::*;

   // step addresses
   localparam logic [UPC_W-1:0] S_IDLE      = 5'd0;
   localparam logic [UPC_W-1:0] S_DISP_BEG  = 5'd1;
   localparam logic [UPC_W-1:0] S_DISP_WR   = 5'd2;
   localparam logic [UPC_W-1:0] S_DISP_END  = 5'd3;
   localparam logic [UPC_W-1:0] S_END       = 5'd4;
   localparam logic [UPC_W-1:0] S_END_DEC   = 5'd5;
   localparam logic [UPC_W-1:0] S_COPY_IN   = 5'd6;
   localparam logic [UPC_W-1:0] S_HDR_CMT   = 5'd7;
   localparam logic [UPC_W-1:0] S_COPY_OUT  = 5'd8;
   localparam logic [UPC_W-1:0] S_HDR_CLR   = 5'd9;
   localparam logic [UPC_W-1:0] S_BEGIN     = 5'd10;
   localparam logic [UPC_W-1:0] S_BEGIN_OK  = 5'd11;
   localparam logic [UPC_W-1:0] S_WRITE     = 5'd12;
   localparam logic [UPC_W-1:0] S_WR_OPEN   = 5'd13;
   localparam logic [UPC_W-1:0] S_SEARCH    = 5'd14;
   localparam logic [UPC_W-1:0] S_CMP       = 5'd15;
   localparam logic [UPC_W-1:0] S_OK        = 5'd16;
   localparam logic [UPC_W-1:0] S_APPEND    = 5'd17;
   localparam logic [UPC_W-1:0] S_ERR_END   = 5'd18;
   localparam logic [UPC_W-1:0] S_ERR_WAIT  = 5'd19;
   localparam logic [UPC_W-1:0] S_ERR_BIG   = 5'd20;
   localparam logic [UPC_W-1:0] S_ERR_WROP  = 5'd21;

   function automatic uword_type rom(input logic [UPC_W-1:0] a);
      uword_type w;
      w = '0;
      unique case (a)
         S_IDLE: begin
            w.cond = C_NO_REQ;  w.target = S_IDLE;
            w.take_req = 1'b1;  w.idx_op = IX_CLR;
         end
         S_DISP_BEG: begin w.cond = C_KIND_BEGIN;   w.target = S_BEGIN; end
         S_DISP_WR:  begin w.cond = C_KIND_WRITE;   w.target = S_WRITE; end
         S_DISP_END: begin w.cond = C_KIND_NOT_END; w.target = S_OK;    end
         S_END:      begin w.cond = C_NO_OPEN;      w.target = S_ERR_END; end
         S_END_DEC: begin
            w.cond = C_NO_COMMIT; w.target = S_OK; w.open_op = OP_DEC;
         end
         S_COPY_IN: begin
            w.cond = C_IDX_NOT_LAST; w.target = S_COPY_IN;
            w.emit = E_COPY_IN;      w.idx_op = IX_INC;
         end
         S_HDR_CMT: begin
            w.cond = C_STOP;        w.target = S_IDLE;
            w.emit = E_HDR_COMMIT;  w.idx_op = IX_CLR; w.last_sel = L_STOP;
         end
         S_COPY_OUT: begin
            w.cond = C_IDX_NOT_LAST; w.target = S_COPY_OUT;
            w.emit = E_COPY_OUT;     w.idx_op = IX_INC;
         end
         S_HDR_CLR: begin
            w.cond = C_ALWAYS;     w.target = S_IDLE;
            w.emit = E_HDR_CLEAR;  w.last_sel = L_YES; w.count_clr = 1'b1;
         end
         S_BEGIN: begin w.cond = C_BEGIN_WAIT; w.target = S_ERR_WAIT; end
         S_BEGIN_OK: begin
            w.cond = C_ALWAYS; w.target = S_IDLE; w.open_op = OP_INC;
            w.emit = E_STATUS; w.status = ST_OK;  w.last_sel = L_YES;
         end
         S_WRITE:   begin w.cond = C_FULL;     w.target = S_ERR_BIG;  end
         S_WR_OPEN: begin w.cond = C_NO_OPEN;  w.target = S_ERR_WROP; end
         S_SEARCH:  begin w.cond = C_IDX_DONE; w.target = S_APPEND;   end
         S_CMP: begin
            w.cond = C_NOT_MATCH; w.target = S_SEARCH; w.idx_op = IX_INC;
         end
         S_OK: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
            w.emit = E_STATUS; w.status = ST_OK; w.last_sel = L_YES;
         end
         S_APPEND: begin
            w.cond = C_ALWAYS; w.target = S_IDLE; w.append = 1'b1;
            w.emit = E_STATUS; w.status = ST_OK;  w.pin = 1'b1;
            w.last_sel = L_YES;
         end
         S_ERR_END: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
            w.emit = E_STATUS; w.status = ST_NO_OP_END; w.last_sel = L_YES;
         end
         S_ERR_WAIT: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
            w.emit = E_STATUS; w.status = ST_WAIT; w.last_sel = L_YES;
         end
         S_ERR_BIG: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
            w.emit = E_STATUS; w.status = ST_TOO_BIG; w.last_sel = L_YES;
         end
         S_ERR_WROP: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
            w.emit = E_STATUS; w.status = ST_NO_OP_WR; w.last_sel = L_YES;
         end
         default: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic             taken;
   logic             go;

   assign ctl = rom(upc_ff);

   always_comb begin
      unique case (ctl.cond)
         C_NEVER:        taken = 1'b0;
         C_ALWAYS:       taken = 1'b1;
         C_NO_REQ:       taken = flags.no_req;
         C_KIND_BEGIN:   taken = flags.kind_begin;
         C_KIND_WRITE:   taken = flags.kind_write;
         C_KIND_NOT_END: taken = flags.kind_not_end;
         C_NO_OPEN:      taken = flags.no_open;
         C_NO_COMMIT:    taken = flags.no_commit;
         C_BEGIN_WAIT:   taken = flags.begin_wait;
         C_FULL:         taken = flags.full;
         C_IDX_DONE:     taken = flags.idx_done;
         C_IDX_NOT_LAST: taken = flags.idx_not_last;
         C_NOT_MATCH:    taken = flags.not_match;
         C_STOP:         taken = flags.stop;
         default:        taken = 1'b0;
      endcase
   end

   // an emitting step waits for room in the output register
   assign go = (ctl.emit == E_NONE) || flags.out_free;

   always_comb begin
      upc_in = upc_ff;
      if (go) begin
         upc_in = taken ? ctl.target : upc_ff + UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/wal_dp.sv */
`default_nettype none

module wal_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  wal_pkg::req_type                   req_data,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output wal_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [wal_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wal_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wal_pkg::uword_type                 ctl,
   output wal_pkg::flags_type                 flags
);
   import wal_pkg::*;

   // configuration
   logic [BLK_W-1:0]  log_start_ff;
   logic [LBLK_W-1:0] log_blocks_ff;
   logic [BPO_W-1:0]  bpo_ff;
   logic              stop_ff;

   // latched request
   logic [KIND_W-1:0] kind_ff;
   logic [BLK_W-1:0]  blk_ff;

   // transaction state
   logic [BLK_W-1:0]  table_ff [LOG_ENTRIES];
   logic [CNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]  open_ff, open_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              go;
   logic              out_free;
   logic              accept;
   logic [BLK_W-1:0]  cur_blk;
   logic [BLK_W-1:0]  slot_blk;
   logic [BPO_W-1:0]  bpo_eff;
   logic [NEED_W-1:0] need;
   rsp_type           item;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = (ctl.emit == E_NONE) || out_free;
   assign accept   = ctl.take_req && req_valid;

   assign cur_blk  = table_ff[idx_ff[IDX_W-1:0]];
   assign slot_blk = log_start_ff + BLK_W'(idx_ff) + BLK_W'(1);
   assign bpo_eff  = (bpo_ff == '0) ? BPO_W'(1) : bpo_ff;
   assign need     = NEED_W'(entry_count_ff)
                   + (NEED_W'(open_ff) + NEED_W'(1)) * NEED_W'(bpo_eff);

   always_comb begin
      flags.no_req       = !req_valid;
      flags.kind_begin   = (kind_ff == KIND_BEGIN);
      flags.kind_write   = (kind_ff == KIND_WRITE);
      flags.kind_not_end = (kind_ff != KIND_END);
      flags.no_open      = (open_ff == '0);
      flags.no_commit    = (open_ff != CNT_W'(1)) || (entry_count_ff == '0);
      flags.begin_wait   = (need > NEED_W'(LOG_ENTRIES));
      flags.full         = (entry_count_ff >= CNT_W'(LOG_ENTRIES))
                        || ((LBLK_W+1)'(entry_count_ff) + (LBLK_W+1)'(1)
                            >= (LBLK_W+1)'(log_blocks_ff));
      flags.idx_done     = (idx_ff == entry_count_ff);
      flags.idx_not_last = ((CNT_W+1)'(idx_ff) + (CNT_W+1)'(1))
                        != (CNT_W+1)'(entry_count_ff);
      flags.not_match    = (cur_blk != blk_ff);
      flags.stop         = stop_ff;
      flags.out_free     = out_free;
   end

   // result item assembly
   always_comb begin
      item = '0;
      unique case (ctl.emit)
         E_STATUS: begin
            item.item_type   = ITEM_STATUS;
            item.status      = ctl.status;
            item.pin_request = ctl.pin;
         end
         E_COPY_IN: begin
            item.item_type    = ITEM_COPY;
            item.source_block = cur_blk;
            item.target_block = slot_blk;
         end
         E_HDR_COMMIT: begin
            item.item_type    = ITEM_HEADER;
            item.target_block = log_start_ff;
            item.header_count = HCNT_W'(entry_count_ff);
         end
         E_COPY_OUT: begin
            item.item_type    = ITEM_COPY;
            item.source_block = slot_blk;
            item.target_block = cur_blk;
         end
         E_HDR_CLEAR: begin
            item.item_type    = ITEM_HEADER;
            item.target_block = log_start_ff;
         end
         default: ;
      endcase
      unique case (ctl.last_sel)
         L_YES:   item.last = 1'b1;
         L_STOP:  item.last = stop_ff;
         default: item.last = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.emit != E_NONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = item;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      idx_in         = idx_ff;
      open_in        = open_ff;
      entry_count_in = entry_count_ff;
      if (go) begin
         unique case (ctl.idx_op)
            IX_CLR:  idx_in = '0;
            IX_INC:  idx_in = idx_ff + CNT_W'(1);
            default: ;
         endcase
         unique case (ctl.open_op)
            OP_INC:  open_in = open_ff + CNT_W'(1);
            OP_DEC:  open_in = open_ff - CNT_W'(1);
            default: ;
         endcase
         if (ctl.append) begin
            entry_count_in = entry_count_ff + CNT_W'(1);
         end else if (ctl.count_clr) begin
            entry_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_start_ff   <= RST_LOG_START;
         log_blocks_ff  <= RST_LOG_BLOCKS;
         bpo_ff         <= RST_BPO;
         stop_ff        <= 1'b0;
         entry_count_ff <= '0;
         open_ff        <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOG_START:  log_start_ff  <= csr_wdata[BLK_W-1:0];
               CSR_LOG_BLOCKS: log_blocks_ff <= csr_wdata[LBLK_W-1:0];
               CSR_BPO:        bpo_ff        <= csr_wdata[BPO_W-1:0];
               CSR_STOP:       stop_ff       <= csr_wdata[0];
            endcase
         end
         entry_count_ff <= entry_count_in;
         open_ff        <= open_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         kind_ff <= req_data.kind;
         blk_ff  <= req_data.block_number;
      end
      if (go && ctl.append) begin
         table_ff[entry_count_ff[IDX_W-1:0]] <= blk_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/write_ahead_log_transaction_tracker.sv */
// Channel | Ports                                | Direction | Carries
// --------+--------------------------------------+-----------+----------------------------
// request | req_valid, req_stall, req_data       | in        | kind, block_number
// result  | rsp_valid, rsp_stall, rsp_data       | out       | one command or status item
// config  | csr_we, csr_index, csr_wdata         | in        | log_start .. stop_after_commit
//
// Sequencing: a microcode step counter runs one step a cycle, except while an emitting
//   step holds on a stalled output; one request at a time. A log write checks
//   for room and an open operation, then searches the table entry by entry and
//   appends the block when no entry matches; a committing end emits n copy-in
//   commands and the commit header, then, unless stop is set, n copy-out commands and
//   a clearing header (n = entry count), one emitted item per cycle while the output drains.
// Reset: synchronous, active high; clears the counts, the sequencer and the
//   registers to their defaults. The block table is not cleared.
// Stalls: an emitting step holds while the output register is full and stalled.
`default_nettype none

module write_ahead_log_transaction_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wal_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wal_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [wal_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wal_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wal_pkg::*;

   uword_type ctl;
   flags_type flags;

   // sequencer: microcode table plus step counter
   wal_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // datapath: block table, counters, output register, config
   wal_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .flags     (flags)
   );

   // only the idle step takes a request
   assign req_stall = !ctl.take_req;

   // once a request is taken the sequencer is busy with it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in flight");

   // copy and header commands never carry a status or pin
   a_cmd_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.item_type != ITEM_STATUS)
         |-> (rsp_data.status == ST_OK && !rsp_data.pin_request))
      else $error("command item carries status bits");

   // a blocked emitting step must not advance
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit != E_NONE && rsp_valid && rsp_stall) |=> $stable(ctl))
      else $error("sequencer advanced past a stalled emit");

endmodule

`default_nettype wire

/* verif/wal_commit_checker.sv */
module wal_commit_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  wal_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  wal_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [wal_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wal_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             outstanding
);
   import wal_pkg::*;

   rsp_type           pending_items[$];
   logic [BLK_W-1:0]  journal[LOG_ENTRIES];
   int                journal_len = 0;
   int                open_ops    = 0;
   int                errs        = 0;

   // shadow of the register file
   logic [BLK_W-1:0]  hdr_block   = RST_LOG_START;
   logic [LBLK_W-1:0] area_blocks = RST_LOG_BLOCKS;
   logic [BPO_W-1:0]  op_budget   = RST_BPO;
   logic              hold_table  = 1'b0;

   task automatic emit(input logic [TYPE_W-1:0] kind, input logic [STAT_W-1:0] st,
                       input logic pin, input logic [BLK_W-1:0] src,
                       input logic [BLK_W-1:0] dst, input logic [HCNT_W-1:0] cnt,
                       input logic fin);
      rsp_type it;
      it.item_type    = kind;
      it.status       = st;
      it.pin_request  = pin;
      it.source_block = src;
      it.target_block = dst;
      it.header_count = cnt;
      it.last         = fin;
      pending_items.push_back(it);
   endtask

   // home -> log slots, commit header; unless the table is held: log slots -> home, clearing header
   task automatic emit_commit_run();
      logic [BLK_W-1:0] slot;
      logic [31:0]      wide;
      int               i;
      wide = journal_len;
      slot = hdr_block;
      for (i = 0; i < journal_len; i++) begin
         slot = slot + 1'b1;
         emit(ITEM_COPY, ST_OK, 1'b0, journal[i], slot, '0, 1'b0);
      end
      emit(ITEM_HEADER, ST_OK, 1'b0, '0, hdr_block, wide[HCNT_W-1:0], hold_table);
      if (!hold_table) begin
         slot = hdr_block;
         for (i = 0; i < journal_len; i++) begin
            slot = slot + 1'b1;
            emit(ITEM_COPY, ST_OK, 1'b0, slot, journal[i], '0, 1'b0);
         end
         emit(ITEM_HEADER, ST_OK, 1'b0, '0, hdr_block, '0, 1'b1);
         journal_len = 0;
      end
   endtask

   task automatic track_request(input req_type r);
      int   budget;
      int   i;
      logic hit;
      budget = (op_budget == '0) ? 1 : int'(op_budget);
      case (r.kind)
         KIND_BEGIN: begin
            if (journal_len + (open_ops + 1) * budget > LOG_ENTRIES) begin
               emit(ITEM_STATUS, ST_WAIT, 1'b0, '0, '0, '0, 1'b1);
            end else begin
               open_ops++;
               emit(ITEM_STATUS, ST_OK, 1'b0, '0, '0, '0, 1'b1);
            end
         end
         KIND_WRITE: begin
            if (journal_len >= LOG_ENTRIES || journal_len + 1 >= int'(area_blocks)) begin
               emit(ITEM_STATUS, ST_TOO_BIG, 1'b0, '0, '0, '0, 1'b1);
            end else if (open_ops == 0) begin
               emit(ITEM_STATUS, ST_NO_OP_WR, 1'b0, '0, '0, '0, 1'b1);
            end else begin
               hit = 1'b0;
               for (i = 0; i < journal_len; i++)
                  if (journal[i] == r.block_number) hit = 1'b1;
               if (!hit) begin
                  journal[journal_len] = r.block_number;
                  journal_len++;
               end
               emit(ITEM_STATUS, ST_OK, !hit, '0, '0, '0, 1'b1);
            end
         end
         KIND_END: begin
            if (open_ops == 0) begin
               emit(ITEM_STATUS, ST_NO_OP_END, 1'b0, '0, '0, '0, 1'b1);
            end else begin
               open_ops--;
               if (open_ops != 0 || journal_len == 0)
                  emit(ITEM_STATUS, ST_OK, 1'b0, '0, '0, '0, 1'b1);
               else
                  emit_commit_run();
            end
         end
         default: emit(ITEM_STATUS, ST_OK, 1'b0, '0, '0, '0, 1'b1);
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errs++;
         $display("%0t result field %s: expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic match_result(input rsp_type got);
      rsp_type want;
      if (pending_items.size() == 0) begin
         errs++;
         $display("%0t result %h arrived with nothing outstanding", $time, got);
         return;
      end
      want = pending_items.pop_front();
      check_field("item_type",    32'(want.item_type),    32'(got.item_type));
      check_field("status",       32'(want.status),       32'(got.status));
      check_field("pin_request",  32'(want.pin_request),  32'(got.pin_request));
      check_field("source_block", 32'(want.source_block), 32'(got.source_block));
      check_field("target_block", 32'(want.target_block), 32'(got.target_block));
      check_field("header_count", 32'(want.header_count), 32'(got.header_count));
      check_field("last",         32'(want.last),         32'(got.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_items.delete();
         journal_len = 0;
         open_ops    = 0;
         hdr_block   = RST_LOG_START;
         area_blocks = RST_LOG_BLOCKS;
         op_budget   = RST_BPO;
         hold_table  = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LOG_START:  hdr_block   = csr_wdata[BLK_W-1:0];
               CSR_LOG_BLOCKS: area_blocks = csr_wdata[LBLK_W-1:0];
               CSR_BPO:        op_budget   = csr_wdata[BPO_W-1:0];
               CSR_STOP:       hold_table  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) track_request(req_data);
         if (rsp_valid && !rsp_stall) match_result(rsp_data);
      end
      outstanding <= pending_items.size();
      mismatches  <= errs;
   end

endmodule

/* verif/tb.sv */
module tb;
   import wal_pkg::*;

   // kind value with no meaning; the tracker must still answer with a plain ok
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   // a commit run of 62 commands under heavy stall stays far below this
   localparam int IDLE_LIMIT   = 4000;
   // trailing sequencer steps after the last result of a request
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 13;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_kind_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int                      mismatches;
   int                      outstanding;
   int                      quiet_cycles = 0;
   int                      stall_tick   = 0;
   stall_kind_type          stall_mode   = STALL_NONE;
   int                      burst_left   = 0;
   int                      sent         = 0;
   // small pool of block numbers so that log writes hit the table often
   logic [BLK_W-1:0]        hot_blocks[8];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   write_ahead_log_transaction_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wal_commit_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Result side backpressure: the pattern, redrawn on the stall tick counter, is one of
   // none, light random, heavy random and a fixed comb, so stalls land
   // on copy commands, headers and status items alike.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 63) stall_mode <= stall_kind_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_tick % 5 < 2);
      endcase
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [BLK_W-1:0] random_block();
      logic [31:0] raw;
      raw = $urandom();
      return raw[BLK_W-1:0];
   endfunction

   // half from the hot pool, a quarter tiny numbers, a quarter anything
   function automatic logic [BLK_W-1:0] pick_block();
      logic [31:0] raw;
      raw = $urandom();
      case (raw[1:0])
         2'd0, 2'd1: return hot_blocks[raw[4:2]];
         2'd2:       return {{(BLK_W-4){1'b0}}, raw[11:8]};
         default:    return random_block();
      endcase
   endfunction

   // Sender pacing: bursts of back-to-back requests, then a short gap.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   // Present one request and hold it until it is taken.
   task automatic send(input logic [KIND_W-1:0] kind, input logic [BLK_W-1:0] blk);
      req_type r;
      r.kind         = kind;
      r.block_number = blk;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      pace();
   endtask

   // Wait for every outstanding result, then let the sequencer wind down.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back while the tracker is idle. The
   // unused upper data bits carry junk; the registers must ignore them.
   task automatic load_config(input logic [31:0] start, input logic [31:0] blocks,
                              input logic [31:0] budget, input logic [31:0] hold);
      logic [31:0] junk;
      settle();
      junk = $urandom();
      csr_we    <= 1'b1;
      csr_index <= CSR_LOG_START;
      csr_wdata <= start[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_LOG_BLOCKS;
      csr_wdata <= {junk[CSR_DATA_W-1:LBLK_W], blocks[LBLK_W-1:0]};
      @(posedge clock);
      csr_index <= CSR_BPO;
      csr_wdata <= {junk[CSR_DATA_W-1:BPO_W], budget[BPO_W-1:0]};
      @(posedge clock);
      csr_index <= CSR_STOP;
      csr_wdata <= {junk[CSR_DATA_W-1:1], hold[0]};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed transactions: nested begins, a run of log writes
   // (now and then long enough to fill the table), matching ends. The rest
   // is single requests of any kind, which break the nesting on purpose.
   task automatic random_transaction();
      logic [31:0] roll;
      int          depth;
      int          writes;
      roll = $urandom();
      if (roll[2:0] < 3'd2) begin
         send(roll[9:8], random_block());
         return;
      end
      depth  = $urandom_range(1, 3);
      writes = (roll[6:4] == 3'd0) ? $urandom_range(16, 34) : $urandom_range(0, 6);
      repeat (depth) send(KIND_BEGIN, random_block());
      repeat (writes) send(KIND_WRITE, pick_block());
      repeat (depth) send(KIND_END, random_block());
   endtask

   initial begin
      int i;
      int phase;
      int phase_start;

      hot_blocks[0] = '0;
      hot_blocks[1] = '1;
      for (i = 2; i < 8; i++) hot_blocks[i] = random_block();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, on reset register values ---
      send(KIND_WRITE, 24'hFFFFFF);   // write with no open operation
      send(KIND_END, 24'h000000);     // end with no open operation
      send(KIND_SPARE, 24'h5A5A5A);   // unused kind
      send(KIND_BEGIN, 24'h000000);
      send(KIND_END, 24'hFFFFFF);     // last end, empty table: plain ok
      send(KIND_BEGIN, 24'h000001);
      send(KIND_BEGIN, 24'h000002);
      send(KIND_BEGIN, 24'h000003);   // three operations use the whole budget
      send(KIND_BEGIN, 24'h000004);   // fourth must wait
      send(KIND_WRITE, 24'h000000);   // new entry, pinned
      send(KIND_WRITE, 24'hFFFFFF);
      send(KIND_WRITE, 24'h000000);   // already logged, absorbed
      send(KIND_END, 24'h000000);
      send(KIND_END, 24'h000000);
      send(KIND_END, 24'h000000);     // last end commits two entries

      // smallest log area, header at the top of the block range: slots wrap
      load_config('hFFFFFF, 2, 1, 0);
      send(KIND_BEGIN, 24'h000000);
      send(KIND_WRITE, 24'h123456);
      send(KIND_WRITE, 24'h654321);   // log area full: too big
      send(KIND_END, 24'h000000);

      // zero budget acts as one; commit stops at the header and keeps the table
      load_config(0, 255, 0, 1);
      send(KIND_BEGIN, 24'h000000);
      send(KIND_WRITE, 24'hAAAAAA);
      send(KIND_WRITE, 24'h555555);
      send(KIND_END, 24'h000000);

      // budget above the table size: every begin waits
      load_config(0, 255, 31, 1);
      send(KIND_BEGIN, 24'h000000);

      // --- random phases ---
      // Phases that can leave a large table behind are followed by one with
      // a budget of one and no stop, so the next commit drains it again.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_config($urandom(), 255, 1, 0);
            1: load_config($urandom(), $urandom_range(2, 40), $urandom_range(1, 30), 0);
            2: load_config($urandom(), 255, $urandom_range(0, 2), 1);
            3: load_config('hFFFFF0, $urandom_range(2, 31), 1, 0);
            4: load_config($urandom(), $urandom_range(0, 255), $urandom_range(0, 31),
                           $urandom_range(0, 1));
            default: load_config($urandom(), 255, 1, 0);
         endcase
         phase_start = sent;
         while (sent - phase_start < PHASE_ITEMS) random_transaction();
      end

      settle();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
rtl/wal_pkg.sv
rtl/wal_seq.sv
rtl/wal_dp.sv
rtl/write_ahead_log_transaction_tracker.sv
verif/wal_commit_checker.sv
verif/tb.sv
